// File: hdl/spq_pkg.sv
// Shared types and codes for the stable priority queue.
package spq_pkg;

  // Default sizing handed to the top level.
  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 16;

  // Field widths fixed by the interface.
  localparam int MODE_W  = 2;
  localparam int IDW     = 16;
  localparam int PRI_W   = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Request kinds.
  localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RM  = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

  // Load select for one slot cell.
  typedef struct packed {
    logic take_new;
    logic take_left;
    logic take_right;
  } cell_cmd_t;

endpackage

// File: hdl/stable_priority_queue_with_removal.sv
// Stable priority queue built from a row of slot cells with a result register.
// Enqueue and dequeue: result in the cycle after the request, one request per cycle
// while results are taken and no remove is pending. Remove: the match vector is
// registered, then the first match is isolated and the slots above it shift down.
// The input waits while a result is held and not taken.
// Reset clears the fill count, the sequencer and the result valid; slot data is not reset.
module stable_priority_queue_with_removal import spq_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MODE_W-1:0]  mode,
  input  logic [IDW-1:0]     item_id,
  input  logic [PRI_W-1:0]   priority_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  status,
  output logic [IDW-1:0]     out_id,
  output logic [PRI_W-1:0]   out_priority,
  output logic [COUNT_W-1:0] count
);

  localparam int FW = $clog2(DEPTH + 1);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  logic               state, state_next;
  logic [FW-1:0]      fill, fill_next;
  logic [DEPTH-1:0]   match_q;

  logic               acc;
  logic [ID_BITS-1:0] key;
  logic [ID_BITS-1:0] cid  [DEPTH];
  logic [PRI_W-1:0]   cpri [DEPTH];
  logic [DEPTH-1:0]   gtv, mv;
  cell_cmd_t          cmd  [DEPTH];

  logic [DEPTH-1:0]   first_hit, above;
  logic [ID_BITS-1:0] rm_id;
  logic [PRI_W-1:0]   rm_pri;

  logic               res_load;
  logic [STAT_W-1:0]  res_status;
  logic [ID_BITS-1:0] res_id;
  logic [PRI_W-1:0]   res_pri;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign key      = ID_BITS'(item_id);

  // Row of slot cells; each one loads the new entry or takes from its left or right neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int L = (i == 0) ? 0 : i - 1;
    localparam int R = (i == DEPTH - 1) ? i : i + 1;
    spq_cell #(.ID_BITS(ID_BITS), .FW(FW), .IDX(i)) u_cell (
      .clk       (clk),
      .cmd       (cmd[i]),
      .new_id    (key),
      .new_pri   (priority_req),
      .left_id   (cid[L]),
      .left_pri  (cpri[L]),
      .right_id  (cid[R]),
      .right_pri (cpri[R]),
      .fill      (fill),
      .key       (key),
      .id        (cid[i]),
      .pri       (cpri[i]),
      .gt        (gtv[i]),
      .match     (mv[i])
    );
  end

  // Isolate the first registered match and mark it and every slot above it.
  assign first_hit = match_q & (~match_q + DEPTH'(1));
  assign above     = match_q | (~match_q + DEPTH'(1));

  // Pick out the entry at the first match.
  always_comb begin
    rm_id  = '0;
    rm_pri = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rm_id  = rm_id  | (cid[i]  & {ID_BITS{first_hit[i]}});
      rm_pri = rm_pri | (cpri[i] & {PRI_W{first_hit[i]}});
    end
  end

  // Cell selects, next fill and the result of the request.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cmd[i] = '0;
    end
    state_next = state;
    fill_next  = fill;
    res_load   = 1'b0;
    res_status = STAT_OK;
    res_id     = '0;
    res_pri    = '0;

    if (state == S_SEARCH) begin
      res_load   = 1'b1;
      state_next = S_IDLE;
      if (|match_q) begin
        for (int i = 0; i < DEPTH; i++) begin
          cmd[i].take_right = above[i];
        end
        fill_next = fill - FW'(1);
        res_id    = rm_id;
        res_pri   = rm_pri;
      end else begin
        res_status = STAT_NOT_FOUND;
      end
    end else if (acc) begin
      res_load = 1'b1;
      case (mode)
        MODE_ENQ: begin
          if (fill == FW'(DEPTH)) begin
            res_status = STAT_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (i == 0) begin
                cmd[i].take_new = gtv[i];
              end else begin
                cmd[i].take_new  = gtv[i] && !gtv[i-1];
                cmd[i].take_left = gtv[i-1];
              end
            end
            fill_next = fill + FW'(1);
          end
        end
        MODE_DEQ: begin
          if (fill == '0) begin
            res_status = STAT_EMPTY;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              cmd[i].take_right = 1'b1;
            end
            fill_next = fill - FW'(1);
            res_id    = cid[0];
            res_pri   = cpri[0];
          end
        end
        MODE_RM: begin
          if (fill == '0) begin
            res_status = STAT_EMPTY;
          end else begin
            res_load   = 1'b0;
            state_next = S_SEARCH;
          end
        end
        default: begin
          res_status = STAT_OK;
        end
      endcase
    end
  end

  // Sequencer, fill count and match vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
    match_q <= mv;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_load) begin
      status       <= res_status;
      out_id       <= IDW'(res_id);
      out_priority <= res_pri;
      count        <= COUNT_W'(fill_next);
    end
  end

endmodule

// File: hdl/spq_cell.sv
// One slot of the sorted queue: holds an entry and compares it with the request.
module spq_cell import spq_pkg::*; #(
  parameter int ID_BITS = ID_BITS_DEF,
  parameter int FW      = 5,
  parameter int IDX     = 0
) (
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic [ID_BITS-1:0] new_id,
  input  logic [PRI_W-1:0]   new_pri,
  input  logic [ID_BITS-1:0] left_id,
  input  logic [PRI_W-1:0]   left_pri,
  input  logic [ID_BITS-1:0] right_id,
  input  logic [PRI_W-1:0]   right_pri,
  input  logic [FW-1:0]      fill,
  input  logic [ID_BITS-1:0] key,
  output logic [ID_BITS-1:0] id,
  output logic [PRI_W-1:0]   pri,
  output logic               gt,
  output logic               match
);

  logic live;

  // A slot is occupied when it lies below the fill count.
  assign live  = FW'(IDX) < fill;
  // The new entry belongs in front of any empty slot or any later priority.
  assign gt    = !live || (pri > new_pri);
  assign match = live && (id == key);

  // Entry storage; the select comes from the queue control.
  always_ff @(posedge clk) begin
    if (cmd.take_new) begin
      id  <= new_id;
      pri <= new_pri;
    end else if (cmd.take_left) begin
      id  <= left_id;
      pri <= left_pri;
    end else if (cmd.take_right) begin
      id  <= right_id;
      pri <= right_pri;
    end
  end

endmodule

// File: hdl/spq_checker.sv
// Port checks for the stable priority queue, bound to the top level.
module spq_checker import spq_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [STAT_W-1:0]  status,
  input logic [IDW-1:0]     out_id,
  input logic [PRI_W-1:0]   out_priority,
  input logic [COUNT_W-1:0] count
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_id)
      && $stable(out_priority) && $stable(count))
    else $error("result changed while stalled");

  // A failed request carries no entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> out_id == '0 && out_priority == '0)
    else $error("failed request returned an entry");

  // An empty report leaves nothing in the queue.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_EMPTY |-> count == '0)
    else $error("empty status with nonzero count");

  // No result is shown right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stable_priority_queue_with_removal spq_checker u_spq_checker (.*);

// File: tb/sv/stable_priority_queue_with_removal_tb.sv
// Self-checking testbench for the stable priority queue with removal by id.
`timescale 1ns / 1ps

module stable_priority_queue_with_removal_tb;
  import spq_pkg::*;

  // The package has no name for the unused request kind, which the queue answers with an OK status and no entry.
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  localparam logic [IDW-1:0] ID_MASK = IDW'((64'd1 << ID_BITS_DEF) - 64'd1);
  localparam int RANDOM_ITEMS = 925;
  localparam int SEGMENT_LEN  = 50;
  localparam int TAIL_ITEMS   = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_NS   = 400_000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDW-1:0]    item_id;
    logic [PRI_W-1:0]  pri;
    logic              drain_first;
  } queue_request_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDW-1:0]     id;
    logic [PRI_W-1:0]   pri;
    logic [COUNT_W-1:0] count;
  } queue_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [MODE_W-1:0]  mode = MODE_NOP;
  logic [IDW-1:0]     item_id = '0;
  logic [PRI_W-1:0]   priority_req = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [STAT_W-1:0]  status;
  logic [IDW-1:0]     out_id;
  logic [PRI_W-1:0]   out_priority;
  logic [COUNT_W-1:0] count;

  stable_priority_queue_with_removal dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .item_id      (item_id),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_id       (out_id),
    .out_priority (out_priority),
    .count        (count)
  );

  // Requests waiting to be sent and results waiting to arrive.
  queue_request_t pending_requests[$];
  queue_result_t  expected_results[$];

  // Shadow copy of the queue contents, head in entry zero.
  logic [IDW-1:0]   held_id  [DEPTH_DEF];
  logic [PRI_W-1:0] held_pri [DEPTH_DEF];
  int               held_count = 0;

  int   fail_count = 0;
  logic req_taken = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   window_left = 0;
  logic idle_on = 1'b0;
  logic allow_idle;

  assign allow_idle = idle_on && (pending_requests.size() > TAIL_ITEMS);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Delete one entry and close the gap behind it.
  function automatic void drop_entry(int pos);
    int i;
    for (i = pos; i + 1 < held_count; i++) begin
      held_id[i]  = held_id[i + 1];
      held_pri[i] = held_pri[i + 1];
    end
    held_count--;
  endfunction

  // Apply one request to the shadow queue and return the result it should give.
  function automatic queue_result_t serve_request(queue_request_t req);
    queue_result_t  res;
    logic [IDW-1:0] key;
    int             pos;
    int             i;
    res = '0;
    res.status = STAT_OK;
    key = req.item_id & ID_MASK;
    case (req.mode)
      MODE_ENQ: begin
        if (held_count >= DEPTH_DEF) begin
          res.status = STAT_FULL;
        end else begin
          // A new entry lands behind every entry of equal or better priority.
          pos = 0;
          while (pos < held_count && held_pri[pos] <= req.pri) pos++;
          for (i = held_count; i > pos; i--) begin
            held_id[i]  = held_id[i - 1];
            held_pri[i] = held_pri[i - 1];
          end
          held_id[pos]  = key;
          held_pri[pos] = req.pri;
          held_count++;
        end
      end
      MODE_DEQ: begin
        if (held_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.id  = held_id[0];
          res.pri = held_pri[0];
          drop_entry(0);
        end
      end
      MODE_RM: begin
        if (held_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          // Only the match nearest the head goes.
          pos = -1;
          for (i = 0; i < held_count && pos < 0; i++) begin
            if (held_id[i] == key) pos = i;
          end
          if (pos < 0) begin
            res.status = STAT_NOT_FOUND;
          end else begin
            res.id  = held_id[pos];
            res.pri = held_pri[pos];
            drop_entry(pos);
          end
        end
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(held_count);
    return res;
  endfunction

  function automatic void add_request(logic [MODE_W-1:0] m, logic [IDW-1:0] id,
                                      logic [PRI_W-1:0] p, logic drain);
    queue_request_t req;
    req.mode        = m;
    req.item_id     = id;
    req.pri         = p;
    req.drain_first = drain;
    pending_requests.push_back(req);
  endfunction

  // Ids mostly come from a small pool so that removals find their entries.
  function automatic logic [IDW-1:0] pick_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return IDW'($urandom_range(0, 7));
    if (roll < 80) return {IDW{1'b1}};
    return IDW'($urandom_range(0, 65535));
  endfunction

  // Turn idling on and off in windows so that calm stretches occur too.
  always @(negedge clk) begin
    if (window_left == 0) begin
      idle_on <= ($urandom_range(0, 3) != 0);
      window_left <= $urandom_range(64, 256);
    end else begin
      window_left <= window_left - 1;
    end
  end

  // Request driver: holds a request until taken, then sends the next one.
  always @(negedge clk) begin
    queue_request_t next_req;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_requests.size() == 0) begin
      in_valid <= 1'b0;
    end else if (pending_requests[0].drain_first && expected_results.size() != 0) begin
      in_valid <= 1'b0;
    end else begin
      next_req = pending_requests.pop_front();
      mode         <= next_req.mode;
      item_id      <= next_req.item_id;
      priority_req <= next_req.pri;
      in_valid     <= 1'b1;
      if (allow_idle && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 16);
    end
  end

  // Result side back-pressure in bursts.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (allow_idle && $urandom_range(0, 11) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check delivered results, then predict for accepted requests.
  always @(posedge clk) begin
    queue_result_t  exp_res;
    queue_request_t taken_req;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: status %0d id %h pri %0d count %0d",
                   $time, status, out_id, out_priority, count);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
            fail_count++;
          end
          if (out_id !== exp_res.id) begin
            $display("%0t: out_id expected %h actual %h", $time, exp_res.id, out_id);
            fail_count++;
          end
          if (out_priority !== exp_res.pri) begin
            $display("%0t: out_priority expected %0d actual %0d",
                     $time, exp_res.pri, out_priority);
            fail_count++;
          end
          if (count !== exp_res.count) begin
            $display("%0t: count expected %0d actual %0d", $time, exp_res.count, count);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        taken_req.mode        = mode;
        taken_req.item_id     = item_id;
        taken_req.pri         = priority_req;
        taken_req.drain_first = 1'b0;
        expected_results.push_back(serve_request(taken_req));
      end
      req_taken <= in_valid && in_ready;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int n;
    int seg_kind;
    int roll;
    logic [MODE_W-1:0] m;

    // Directed: empty cases, ordering of equal priorities, duplicate ids,
    // extreme ids, a miss, then fill to the top and push past it.
    add_request(MODE_DEQ, 16'h0000, 2'd0, 1'b0);
    add_request(MODE_RM,  16'h0000, 2'd0, 1'b0);
    add_request(MODE_ENQ, 16'hFFFF, 2'd3, 1'b0);
    add_request(MODE_ENQ, 16'h0000, 2'd0, 1'b0);
    add_request(MODE_ENQ, 16'h0005, 2'd3, 1'b0);
    add_request(MODE_ENQ, 16'h0005, 2'd1, 1'b0);
    add_request(MODE_RM,  16'h0005, 2'd0, 1'b0);
    add_request(MODE_RM,  16'h1234, 2'd2, 1'b0);
    add_request(MODE_DEQ, 16'hAAAA, 2'd3, 1'b0);
    for (n = 0; n < DEPTH_DEF - 2; n++) begin
      add_request(MODE_ENQ, IDW'(16'hA000 + n), PRI_W'(n % 4), 1'b0);
    end
    add_request(MODE_ENQ, 16'h5555, 2'd0, 1'b1);
    add_request(MODE_NOP, 16'hFFFF, 2'd3, 1'b0);

    // Random: segments lean toward filling, draining or neither.
    seg_kind = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_LEN == 0) seg_kind = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        m = MODE_NOP;
      end else if (roll < (seg_kind == 0 ? 72 : (seg_kind == 1 ? 30 : 50))) begin
        m = MODE_ENQ;
      end else if ($urandom_range(0, 1) == 0) begin
        m = MODE_DEQ;
      end else begin
        m = MODE_RM;
      end
      add_request(m, pick_id(), PRI_W'($urandom_range(0, 3)), (n % 300 == 150));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("** stable_priority_queue_with_removal: PASSED **");
    end else begin
      $display("** stable_priority_queue_with_removal: FAILED **");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout", $time);
    $display("** stable_priority_queue_with_removal: FAILED **");
    $finish;
  end

endmodule

// File: files.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue_with_removal.sv
hdl/spq_checker.sv
tb/sv/stable_priority_queue_with_removal_tb.sv
